// File: design/srr_pkg.sv
// Shared types and constants for the selective repeat receiver.
package srr_pkg;

  // Internal width of sequence numbers and the receive base
  localparam int BASE_W = 32;

  // Configuration register indexes
  localparam logic [7:0] CFG_WINDOW_SIZE    = 8'd0;
  localparam logic [7:0] CFG_SESSION_LENGTH = 8'd1;

  // Configuration register set
  typedef struct packed {
    logic [6:0]  window_size;
    logic [30:0] session_length;
  } cfg_t;

  // One classified message between front and back
  typedef struct packed {
    logic signed [BASE_W-1:0] seq;
    logic                     neg;
  } item_t;

endpackage

// File: design/selective_repeat_receiver.sv
// Selective repeat receiver top level: config registers, front, queue and back.
//
// Usage: each beat on the s_axis channel carries the sequence number of an
// arriving message; every accepted beat yields exactly one beat on m_axis
// with the cumulative ack (tdata) and the session-done flag (tuser).
// The cfg channel writes window_size (index 0) and session_length (index 1);
// it is always ready; the user must write it only while the block is idle,
// the block itself does not enforce this. The input stage registers each
// beat and the queue holds it; the engine then goes from idle to the emit
// state for an out-of-order or ignored number, and through the slide state
// for an in-order number that slides the base; the slide walks the received
// bitmap one ring entry per cycle. The engine takes no new number until it
// has loaded the ack for the last one. Reset clears the base to -1, the
// bitmap, both registers to 1 and all valid flags. When m_axis stalls, the
// held ack stays put, the engine waits, and the queue and input stage fill
// before s_axis_tready drops.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW_MAX = 64,
  parameter int SEQ_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SEQ_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,   // rcv_seq
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SEQ_WIDTH + 7) / 8)*8-1:0] m_axis_tdata,   // ack_seq
  output logic                              m_axis_tuser,   // session_done
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int DATA_W = ((SEQ_WIDTH + 7) / 8) * 8;

  cfg_t  cfg;
  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size    <= 7'd1;
      cfg.session_length <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:    cfg.window_size    <= cfg_data[6:0];
        CFG_SESSION_LENGTH: cfg.session_length <= cfg_data[30:0];
        default:            ;
      endcase
    end
  end

  srr_front #(
    .SEQ_WIDTH (SEQ_WIDTH),
    .IN_W      (DATA_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid    (f_valid),
    .item_ready    (f_ready),
    .item          (f_item)
  );

  srr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  srr_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .SEQ_WIDTH  (SEQ_WIDTH),
    .OUT_W      (DATA_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: design/srr_front.sv
// Input stage: takes message beats, sign-extends and classifies the sequence number.
module srr_front
  import srr_pkg::*;
#(
  parameter int SEQ_WIDTH = 32,
  parameter int IN_W      = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,   // [SEQ_WIDTH-1:0] rcv_seq, rest zero
  output logic            item_valid,
  input  logic            item_ready,
  output item_t           item
);

  logic signed [SEQ_WIDTH-1:0] seq_raw;
  logic signed [BASE_W-1:0]    seq_ext;

  // Sign extension to the internal width
  assign seq_raw = $signed(s_axis_tdata[SEQ_WIDTH-1:0]);
  assign seq_ext = BASE_W'(seq_raw);

  // Single holding stage
  assign s_axis_tready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item.seq <= seq_ext;
      item.neg <= seq_ext[BASE_W-1];
    end
  end

endmodule

// File: design/srr_queue.sv
// Two-entry queue between the front and back parts.
module srr_queue
  import srr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// File: design/srr_back.sv
// Window engine: marks received numbers, slides the base, holds the ack beat.
module srr_back
  import srr_pkg::*;
#(
  parameter int WINDOW_MAX = 64,
  parameter int SEQ_WIDTH  = 32,
  parameter int OUT_W      = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // [SEQ_WIDTH-1:0] ack_seq, rest zero
  output logic             m_axis_tuser   // session_done
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SLIDE, S_EMIT} state_t;

  state_t                   state;
  logic signed [BASE_W-1:0] base;
  logic [IW-1:0]            head;      // ring position of base + 1
  logic [WINDOW_MAX-1:0]    rmap;
  logic [SEQ_WIDTH-1:0]     ack;

  logic signed [BASE_W:0]   base_x;
  logic signed [BASE_W:0]   base1;
  logic signed [BASE_W:0]   len_x;
  logic signed [BASE_W:0]   w_x;
  logic signed [BASE_W:0]   win_end;
  logic signed [BASE_W:0]   seq_x;
  logic signed [BASE_W:0]   off_full;
  logic [IW:0]              pos_sum;
  logic [IW-1:0]            mark_pos;
  logic [IW-1:0]            head_inc;
  logic                     in_win;
  logic                     in_order;
  logic                     can_step;
  logic                     done_now;
  logic                     out_free;

  // Window arithmetic on sign-extended values
  always_comb begin
    base_x  = {base[BASE_W-1], base};
    base1   = base_x + 33'sd1;
    len_x   = $signed({2'b00, cfg.session_length});
    w_x     = $signed({26'd0, cfg.window_size});
    if (w_x > $signed(33'(WINDOW_MAX))) w_x = $signed(33'(WINDOW_MAX));
    win_end = base1 + w_x;
    if (win_end > len_x) win_end = len_x;
    seq_x    = {item.seq[BASE_W-1], item.seq};
    in_win   = !item.neg && (seq_x > base_x) && (seq_x < win_end);
    in_order = (seq_x == base1);
    // Offset from base + 1 stays below the window, so one wrap suffices
    off_full = seq_x - base1;
    pos_sum  = {1'b0, head} + {1'b0, off_full[IW-1:0]};
    if (pos_sum >= (IW+1)'(WINDOW_MAX)) pos_sum = pos_sum - (IW+1)'(WINDOW_MAX);
    mark_pos = pos_sum[IW-1:0];
    head_inc = (head == IW'(WINDOW_MAX - 1)) ? '0 : head + IW'(1);
    can_step = (base1 < len_x) && rmap[head];
    done_now = (base_x >= (len_x - 33'sd1));
    out_free = !m_axis_tvalid || m_axis_tready;
  end

  assign item_ready   = (state == S_IDLE);
  assign m_axis_tdata = OUT_W'(ack);

  // Sequencer, bitmap and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      base          <= '1;
      head          <= '0;
      rmap          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Beat taken: drop valid unless the emit state reloads it
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (in_win) rmap[mark_pos] <= 1'b1;
            state <= in_order ? S_SLIDE : S_EMIT;
          end
        end
        S_SLIDE: begin
          // One ring entry per cycle
          if (can_step) begin
            rmap[head] <= 1'b0;
            base       <= base + BASE_W'(1);
            head       <= head_inc;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            ack           <= base[SEQ_WIDTH-1:0];
            m_axis_tuser  <= done_now;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
